@@ rtl/bba_pkg.sv @@
`default_nettype none
package bba_pkg;

  typedef struct packed {
    logic        mode;
    logic [15:0] request_size;
    logic [16:0] free_address;
  } bba_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [16:0] block_address;
  } bba_out_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADSIZE = 2'd1;
  localparam logic [1:0] ST_NOMEM   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_SCAN,
    S_A_CLAIM,
    S_A_UNL,
    S_A_FIXN,
    S_A_BODY,
    S_F_CHK,
    S_F_BUD,
    S_F_BCHK,
    S_F_FIXP,
    S_F_FIXN,
    S_F_HI,
    S_F_PUSH,
    S_F_PFIX,
    S_DONE
  } bba_state_t;

endpackage
`default_nettype wire

@@ rtl/buddy_block_allocator_core.sv @@
// An allocate scans up the levels for a free block (claiming a new top block if none is
// found), then splits it down; a free merges with its free buddy level by level, then pushes.
// One transaction at a time; busy stays high through the done cycle, so the next accept
// comes in the cycle after done at the earliest.
// Reset: synchronous; busy then stays high while the metadata memory clears all GRANULES
// words (512 by default). The result shows for the one done cycle; the receiver cannot stall.
`default_nettype none
module buddy_block_allocator_core
  import bba_pkg::*;
#(
  parameter int LEVELS     = 8,
  parameter int BASE_SHIFT = 8,
  parameter int TOP_BLOCKS = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire bba_in_t    in_item,
  output logic            done,
  output bba_out_t        out_item,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_data
);

  localparam int TOP_LEVEL = LEVELS - 1;
  localparam int TBW       = $clog2(TOP_BLOCKS + 1);
  localparam int GRANULES  = TOP_BLOCKS << TOP_LEVEL;
  localparam int GW        = $clog2(GRANULES + 1);   // holds NIL
  localparam int AW        = (GRANULES > 1) ? $clog2(GRANULES) : 1;
  localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [GW-1:0] NIL       = GW'(GRANULES);
  localparam logic [AW-1:0] LAST_G    = AW'(GRANULES - 1);
  localparam logic [LW-1:0] TOP_LV    = LW'(TOP_LEVEL);
  localparam logic [31:0]   TOP_BYTES = 32'(1) << (BASE_SHIFT + TOP_LEVEL);
  localparam logic [31:0]   OFS_MASK  = (32'(1) << BASE_SHIFT) - 32'(1);

  // One metadata word per granule: start, allocated, level, prev, next.
  typedef struct packed {
    logic          bstart;
    logic          alloc;
    logic [LW-1:0] lvl;
    logic [GW-1:0] prev;
    logic [GW-1:0] next;
  } meta_t;

  meta_t         mem [GRANULES];
  meta_t         rd_word;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  meta_t         wdata;

  // Forward a same-cycle write to the read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && waddr == raddr) begin
      rd_word <= wdata;
    end else begin
      rd_word <= mem[raddr];
    end
  end

  logic [GW-1:0]  head [LEVELS];
  logic [TBW-1:0] claimed;
  logic [2:0]     enabled;
  bba_state_t     state, state_next;
  logic [AW-1:0]  clr;
  logic [LW-1:0]  lv, k;          // target level, working level
  logic [AW-1:0]  g, b;           // current granule, buddy
  logic [GW-1:0]  pp, nn;         // list neighbors being patched
  logic [1:0]     st;
  logic [16:0]    addr_out;

  logic [31:0]    req32, fa32, g_bytes;
  logic [LW-1:0]  size_lv, k_dn, k_up;
  logic           size_bad, free_bad, merge_ok;
  logic [AW-1:0]  in_g, buddy, upper, hi_g, lo_g;
  logic [TBW-1:0] limit;

  assign req32    = 32'(in_item.request_size);
  assign fa32     = 32'(in_item.free_address);
  assign in_g     = AW'(fa32 >> BASE_SHIFT);
  assign size_bad = (req32 == 32'd0) || (req32 > TOP_BYTES);
  assign free_bad = ((fa32 & OFS_MASK) != 32'd0) ||
                    ((fa32 >> BASE_SHIFT) >= 32'(GRANULES));
  assign k_dn     = k - LW'(1);
  assign k_up     = k + LW'(1);
  assign buddy    = g ^ (AW'(1) << k);
  assign upper    = g + (AW'(1) << k_dn);
  assign hi_g     = (b > g) ? b : g;
  assign lo_g     = (b > g) ? g : b;
  assign merge_ok = rd_word.bstart && !rd_word.alloc && rd_word.lvl == k;
  assign g_bytes  = 32'(g) << BASE_SHIFT;

  // level from size: smallest level whose block holds the request
  always_comb begin
    size_lv = TOP_LV;
    for (int i = TOP_LEVEL - 1; i >= 0; i--) begin
      if (req32 <= (32'(1) << (BASE_SHIFT + i))) size_lv = LW'(i);
    end
  end

  always_comb begin
    if (32'(enabled) < 32'(TOP_BLOCKS)) limit = TBW'(enabled);
    else limit = TBW'(TOP_BLOCKS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 3'd4;
    end else if (cfg_we) begin
      enabled <= cfg_data;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (clr == LAST_G) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (in_item.mode == MODE_FREE) state_next = free_bad ? S_DONE : S_F_CHK;
          else state_next = size_bad ? S_DONE : S_A_SCAN;
        end
      end
      S_A_SCAN: begin
        if (head[k] != NIL) state_next = S_A_UNL;
        else if (k == TOP_LV) state_next = S_A_CLAIM;
      end
      S_A_CLAIM: state_next = (claimed >= limit) ? S_DONE : S_A_BODY;
      S_A_UNL:   state_next = (rd_word.next != NIL) ? S_A_FIXN : S_A_BODY;
      S_A_FIXN:  state_next = S_A_BODY;
      S_A_BODY:  if (k == lv) state_next = S_DONE;
      S_F_CHK: begin
        if (!rd_word.bstart || !rd_word.alloc) state_next = S_DONE;
        else if (rd_word.lvl == TOP_LV) state_next = S_F_PUSH;
        else state_next = S_F_BUD;
      end
      S_F_BUD:   state_next = S_F_BCHK;
      S_F_BCHK: begin
        if (!merge_ok) state_next = S_F_PUSH;
        else if (rd_word.prev != NIL) state_next = S_F_FIXP;
        else if (rd_word.next != NIL) state_next = S_F_FIXN;
        else state_next = S_F_HI;
      end
      S_F_FIXP:  state_next = (nn != NIL) ? S_F_FIXN : S_F_HI;
      S_F_FIXN:  state_next = S_F_HI;
      S_F_HI:    state_next = (k_up == TOP_LV) ? S_F_PUSH : S_F_BUD;
      S_F_PUSH:  state_next = (head[k] != NIL) ? S_F_PFIX : S_DONE;
      S_F_PFIX:  state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    we    = 1'b0;
    waddr = g;
    wdata = '0;
    raddr = g;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr;
      end
      S_IDLE:   raddr = in_g;
      S_A_SCAN: raddr = AW'(head[k]);
      S_A_UNL:  raddr = AW'(rd_word.next);
      S_A_FIXN: begin
        we         = 1'b1;
        waddr      = AW'(nn);
        wdata      = rd_word;
        wdata.prev = NIL;
      end
      S_A_BODY: begin
        we = 1'b1;
        if (k == lv) begin
          wdata = '{bstart: 1'b1, alloc: 1'b1, lvl: lv, prev: NIL, next: NIL};
        end else begin
          // upper half stays free alone on its level; the lower half goes on down
          waddr = upper;
          wdata = '{bstart: 1'b1, alloc: 1'b0, lvl: k_dn, prev: NIL, next: NIL};
        end
      end
      S_F_BUD:  raddr = buddy;
      S_F_BCHK: raddr = (rd_word.prev != NIL) ? AW'(rd_word.prev) : AW'(rd_word.next);
      S_F_FIXP: begin
        we         = 1'b1;
        waddr      = AW'(pp);
        wdata      = rd_word;
        wdata.next = nn;
        raddr      = AW'(nn);
      end
      S_F_FIXN: begin
        we         = 1'b1;
        waddr      = AW'(nn);
        wdata      = rd_word;
        wdata.prev = pp;
      end
      S_F_HI: begin
        we    = 1'b1;
        waddr = hi_g;
      end
      S_F_PUSH: begin
        we    = 1'b1;
        wdata = '{bstart: 1'b1, alloc: 1'b0, lvl: k, prev: NIL, next: head[k]};
        raddr = AW'(head[k]);
      end
      S_F_PFIX: begin
        we         = 1'b1;
        waddr      = AW'(nn);
        wdata      = rd_word;
        wdata.prev = GW'(g);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      claimed  <= '0;
      for (int i = 0; i < LEVELS; i++) head[i] <= NIL;
      lv       <= '0;
      k        <= '0;
      g        <= '0;
      b        <= '0;
      pp       <= NIL;
      nn       <= NIL;
      st       <= ST_OK;
      addr_out <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: clr <= clr + AW'(1);
        S_IDLE: begin
          if (start) begin
            lv       <= size_lv;
            k        <= size_lv;
            g        <= in_g;
            addr_out <= '0;
            if (in_item.mode == MODE_FREE) st <= free_bad ? ST_IGNORED : ST_OK;
            else st <= size_bad ? ST_BADSIZE : ST_OK;
          end
        end
        S_A_SCAN: begin
          if (head[k] != NIL) g <= AW'(head[k]);
          else if (k != TOP_LV) k <= k_up;
        end
        S_A_CLAIM: begin
          if (claimed >= limit) begin
            st <= ST_NOMEM;
          end else begin
            g       <= AW'(32'(claimed) << TOP_LEVEL);
            claimed <= claimed + TBW'(1);
          end
        end
        S_A_UNL: begin
          // pop the head: it has no predecessor
          head[k] <= rd_word.next;
          nn      <= rd_word.next;
        end
        S_A_BODY: begin
          if (k == lv) begin
            addr_out <= g_bytes[16:0];
          end else begin
            head[k_dn] <= GW'(upper);
            k          <= k_dn;
          end
        end
        S_F_CHK: begin
          if (!rd_word.bstart || !rd_word.alloc) st <= ST_IGNORED;
          else k <= rd_word.lvl;
        end
        S_F_BUD: b <= buddy;
        S_F_BCHK: begin
          if (merge_ok) begin
            pp <= rd_word.prev;
            nn <= rd_word.next;
            if (rd_word.prev == NIL) head[k] <= rd_word.next;
          end
        end
        S_F_HI: begin
          g <= lo_g;
          k <= k_up;
        end
        S_F_PUSH: begin
          head[k] <= GW'(g);
          nn      <= head[k];
        end
        default: begin
        end
      endcase
    end
  end

  assign busy     = (state != S_IDLE);
  assign done     = (state == S_DONE);
  assign out_item = '{status: st, block_address: addr_out};

endmodule
`default_nettype wire
